@@ rtl/sbad_pkg.sv @@
// Shared constants and a digit helper for the signed binary to ASCII decimal converter.
package sbad_pkg;

  localparam int unsigned MagWidth  = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned CntWidth  = $clog2(NumDigits + 1);
  localparam int unsigned BitWidth  = $clog2(MagWidth);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // Add 3 to a BCD digit of 5 or more so the following shift carries correctly.
  function automatic logic [3:0] dabble_adjust(input logic [3:0] digit);
    logic [3:0] res;
    res = (digit >= 4'd5) ? digit + 4'd3 : digit;
    return res;
  endfunction

endpackage

@@ rtl/signed_binary_to_ascii_decimal.sv @@
// Steps: after an item is taken, bit-serial shift-and-add-3 over all 64 magnitude bits, then
//   leading zeros are dropped one digit at a time, then the sign, if any, and the digits go out.
// Back-pressure on the output can hold the sign and the digits; a new item is not taken until
//   every character of the previous one has been loaded into the output register.
// The input is taken only between items; one result register holds the current character.
// Reset (rst_ni low, asynchronous) returns the controller to idle and empties the output.
module signed_binary_to_ascii_decimal (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sbad_pkg::MagWidth-1:0] s_axis_tdata,   // [63:0] value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] text_char
  output logic                          m_axis_tlast    // last_char
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  localparam int unsigned BW = sbad_pkg::BcdWidth;

  logic [2:0]                    state_q, state_d;
  logic [sbad_pkg::MagWidth-1:0] mag_q, mag_d;
  logic [BW-1:0]                 bcd_q, bcd_d;
  logic [BW-1:0]                 bcd_adj;
  logic [sbad_pkg::BitWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [sbad_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_char_q, out_char_d;
  logic                          out_last_q, out_last_d;
  logic                          out_free;
  logic [3:0]                    top_digit;

  assign top_digit     = bcd_q[BW-1 -: 4];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    for (int i = 0; i < sbad_pkg::NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = sbad_pkg::dabble_adjust(bcd_q[i*4 +: 4]);
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          neg_d     = s_axis_tdata[sbad_pkg::MagWidth-1];
          mag_d     = neg_d ? (~s_axis_tdata + sbad_pkg::MagWidth'(1)) : s_axis_tdata;
          bcd_d     = '0;
          bit_cnt_d = '0;
          cnt_d     = sbad_pkg::CntWidth'(sbad_pkg::NumDigits);
          state_d   = StConv;
        end
      end
      StConv: begin
        // adjust every digit, then shift the next magnitude bit in
        bcd_d     = {bcd_adj[BW-2:0], mag_q[sbad_pkg::MagWidth-1]};
        mag_d     = {mag_q[sbad_pkg::MagWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + sbad_pkg::BitWidth'(1);
        if (bit_cnt_q == sbad_pkg::BitWidth'(sbad_pkg::MagWidth - 1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        // drop one leading zero a cycle, always keep the last digit
        if (cnt_q > sbad_pkg::CntWidth'(1) && top_digit == 4'd0) begin
          bcd_d = {bcd_q[BW-5:0], 4'd0};
          cnt_d = cnt_q - sbad_pkg::CntWidth'(1);
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sbad_pkg::CharMinus;
          out_last_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sbad_pkg::CharZero + {4'd0, top_digit};
          out_last_d  = (cnt_q == sbad_pkg::CntWidth'(1));
          bcd_d       = {bcd_q[BW-5:0], 4'd0};
          cnt_d       = cnt_q - sbad_pkg::CntWidth'(1);
          if (cnt_q == sbad_pkg::CntWidth'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    bit_cnt_q  <= bit_cnt_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == StConv)
    else $error("accepted item did not start conversion");

  a_digit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSkip || state_q == StSign || state_q == StEmit) |->
      (cnt_q >= sbad_pkg::CntWidth'(1) &&
       cnt_q <= sbad_pkg::CntWidth'(sbad_pkg::NumDigits)))
    else $error("digit count out of range");

  a_emit_valid_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> top_digit <= 4'd9)
    else $error("emitted digit is not decimal");

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata != sbad_pkg::CharMinus)
    else $error("sign flagged as last character");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the signed binary to ASCII decimal converter: directed table plus random values.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DirCount   = 23;
  localparam int RandCount  = 437;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  text_char_t  pending_chars[$];
  int          mismatches;
  int          items_taken;
  int          idle_cycles;
  bit          quiet;

  // Rows with text are checked against the typed string, empty rows against the predictor.
  logic [63:0] dir_value [DirCount] = '{
    64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'd99, 64'd100, -64'sd100,
    64'd999999999999999999, 64'd1000000000000000000, -64'sd1000000000000000000,
    64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'd12345, -64'sd42, 64'd2147483647, -64'sd2147483648
  };
  string dir_text [DirCount] = '{
    "0", "1", "-1", "9", "10", "-10",
    "9223372036854775807", "-9223372036854775808", "-9223372036854775807",
    "99", "100", "",
    "999999999999999999", "1000000000000000000", "-1000000000000000000",
    "", "4294967295",
    "", "",
    "12345", "-42", "", ""
  };

  signed_binary_to_ascii_decimal dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void push_char(input logic [7:0] code, input logic last);
    text_char_t c;
    c.code = code;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  // Queue the decimal text of a two's complement value, sign first, no leading zeros.
  function automatic void predict_decimal_text(input logic [63:0] value);
    logic [63:0] mag;
    logic [3:0]  digits [sbad_pkg::NumDigits];
    int          n;
    mag = value[63] ? (~value + 64'd1) : value;
    n = 0;
    if (value[63]) begin
      push_char(sbad_pkg::CharMinus, 1'b0);
    end
    do begin
      digits[n] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      n++;
    end while (mag != 64'd0);
    for (int i = n - 1; i >= 0; i--) begin
      push_char(sbad_pkg::CharZero + 8'(digits[i]), i == 0);
    end
  endfunction

  task automatic offer_value(input logic [63:0] value, input string text);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    items_taken++;
    if (text.len() != 0) begin
      for (int i = 0; i < text.len(); i++) begin
        push_char(8'(text[i]), i == text.len() - 1);
      end
    end else begin
      predict_decimal_text(value);
    end
  endtask

  initial begin : stimulus
    logic [63:0] v;
    int          kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    items_taken   = 0;
    quiet         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      offer_value(dir_value[i], dir_text[i]);
    end

    for (int i = 0; i < RandCount; i++) begin
      // Drain the converter once with the input held idle.
      if (i == 80) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_chars.size() != 0);
      end
      quiet = (i >= 200 && i < 290);
      kind = $urandom_range(0, 3);
      unique case (kind)
        0: v = {$urandom, $urandom};
        1: v = 64'($urandom_range(0, 1000));
        2: v = {$urandom, $urandom} >> $urandom_range(1, 63);
        default: begin
          // Land next to a power of ten to move the digit count.
          v = 64'd1;
          repeat ($urandom_range(0, 18)) v = v * 64'd10;
          v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end
      endcase
      if (kind != 0 && $urandom_range(0, 1) == 1) begin
        v = ~v + 64'd1;
      end
      offer_value(v, "");
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Output side: random back-pressure plus one long hold-off that backs up the input.
  initial begin : char_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_taken >= 320) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin : char_check
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", m_axis_tdata,
                                  m_axis_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.code) begin
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", m_axis_tdata, want.code));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b on char 0x%02h", m_axis_tlast,
                                    want.last, want.code));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
